@@ rtl/core/stbs_pkg.sv @@
package stbs_pkg;

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int KEY_IN_W = 32;
	localparam int POS_W = 10;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic start;     // latch key, open full range
		logic load_wr;   // write key into table
		logic issue_rd;  // read table at midpoint
		logic cmp_upd;   // compare read key, narrow range
		logic res_ld;    // move result into output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_open;  // low still below exclusive high
		logic hit;         // read key equals searched key
	} dp_stat_t;

endpackage

@@ rtl/core/stbs_ctrl.sv @@
module stbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  stbs_pkg::dp_stat_t   stat,
	output stbs_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_CMP   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.start    = in_accept && (mode == stbs_pkg::MODE_SEARCH);
		cmd.load_wr  = in_accept && (mode == stbs_pkg::MODE_LOAD);
		cmd.issue_rd = (state_q == ST_CHECK) && stat.range_open;
		cmd.cmp_upd  = (state_q == ST_CMP);
		cmd.res_ld   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.range_open ? ST_CMP : ST_FIN;
			end
			ST_CMP: begin
				state_d = stat.hit ? ST_FIN : ST_CHECK;
			end
			ST_FIN: begin
				if (cmd.res_ld)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// compare needs the table read issued in the previous cycle
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_upd |-> $past(cmd.issue_rd))
		else $error("compare without table read");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");

	a_no_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_rd |-> stat.range_open)
		else $error("table read outside search range");

endmodule

@@ rtl/core/stbs_dp.sv @@
module stbs_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic [stbs_pkg::INDEX_W-1:0]  entry_index,
	input  logic [stbs_pkg::KEY_IN_W-1:0] key_value,
	output logic                          found,
	output logic [stbs_pkg::POS_W-1:0]    position,
	input  stbs_pkg::ctrl_cmd_t           cmd,
	output stbs_pkg::dp_stat_t            stat
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = 18;

	logic [KEY_BITS-1:0] mem [TABLE_DEPTH];

	logic [stbs_pkg::COUNT_W-1:0] entry_count_q;
	logic [CW-1:0]       lo_q, hi_q;   // hi_q is exclusive
	logic [KEY_BITS-1:0] key_q, rd_q;
	logic [AW-1:0]       mid_q;
	logic                hit_q;
	logic                found_q;
	logic [stbs_pkg::POS_W-1:0] pos_q;

	logic [WW-1:0]       idx_w, cnt_w, mid_w;
	logic [63:0]         key_w;
	logic [KEY_BITS-1:0] key_k;
	logic [CW-1:0]       cnt_lim;
	logic [CW:0]         sum_w;
	logic [AW-1:0]       mid_addr;

	assign idx_w = WW'(entry_index);
	assign cnt_w = WW'(entry_count_q);
	assign key_w = 64'(key_value);
	assign key_k = key_w[KEY_BITS-1:0];
	assign cnt_lim = (cnt_w > WW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_w[CW-1:0];

	// floor((lo + hi) / 2) with inclusive hi = hi_q - 1
	assign sum_w    = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid_addr = sum_w[AW:1];
	assign mid_w    = WW'(mid_q);

	assign stat.range_open = (lo_q < hi_q);
	assign stat.hit        = (rd_q == key_q);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (idx_w < WW'(TABLE_DEPTH)))
			mem[idx_w[AW-1:0]] <= key_k;
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_rd)
			rd_q <= mem[mid_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_count_q <= '0;
		else if (cfg_we)
			entry_count_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q  <= '0;
			hi_q  <= cnt_lim;
			key_q <= key_k;
			hit_q <= 1'b0;
		end
		if (cmd.issue_rd)
			mid_q <= mid_addr;
		if (cmd.cmp_upd) begin
			if (stat.hit)
				hit_q <= 1'b1;
			else if (rd_q < key_q)
				lo_q <= mid_w[CW-1:0] + CW'(1);
			else
				hi_q <= mid_w[CW-1:0];
		end
		if (cmd.res_ld) begin
			found_q <= hit_q;
			pos_q   <= hit_q ? mid_w[stbs_pkg::POS_W-1:0] : '0;
		end
	end

	assign found    = found_q;
	assign position = pos_q;

	// every miss strictly narrows the range
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cmp_upd && !stat.hit) |=> ((lo_q > $past(lo_q)) || (hi_q < $past(hi_q))))
		else $error("search range did not narrow");

endmodule

@@ rtl/core/sorted_table_binary_search_top.sv @@
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | mode, entry_index, key_value
// out     | out_valid| out_stall | found, position
// cfg     | cfg_we   | -         | cfg_wdata (entry_count)
//
// Load request: written at the accepting edge, no result.
// Search request: each probe is a registered read then a compare, up to ceil(log2(count+1))
// probes, one more range check on a miss to see the closed range, then the result is loaded
// into the output register with out_valid; the next request is taken once the search is done.
// Reset clears control and entry_count; table contents are undefined until loaded.
// Input is stalled while a search runs; a held result blocks only the next search's finish.
module sorted_table_binary_search_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [stbs_pkg::INDEX_W-1:0]  entry_index,
	input  logic [stbs_pkg::KEY_IN_W-1:0] key_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [stbs_pkg::POS_W-1:0]    position
);

	stbs_pkg::ctrl_cmd_t cmd;
	stbs_pkg::dp_stat_t  stat;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.entry_index (entry_index),
		.key_value   (key_value),
		.found       (found),
		.position    (position),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

@@ tb/sv/sorted_table_binary_search_top_test.sv @@
`timescale 1ns / 1ps

module sorted_table_binary_search_top_test;

	localparam int TABLE_DEPTH = 1024;
	localparam int ITEM_TARGET = 1825;
	localparam int SETTLE_CYCLES = 30;
	localparam int IDLE_LIMIT = 2000;

	typedef logic [stbs_pkg::INDEX_W-1:0] index_t;
	typedef logic [stbs_pkg::COUNT_W-1:0] count_t;

	typedef struct packed {
		logic [stbs_pkg::KEY_IN_W-1:0] key;
		logic                          hit;
		logic [stbs_pkg::POS_W-1:0]    pos;
	} search_result_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          mode = stbs_pkg::MODE_LOAD;
	logic [stbs_pkg::INDEX_W-1:0]  entry_index = '0;
	logic [stbs_pkg::KEY_IN_W-1:0] key_value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          found;
	logic [stbs_pkg::POS_W-1:0]    position;

	// shadow copy of the table and the count register
	logic [stbs_pkg::KEY_IN_W-1:0] key_mirror [TABLE_DEPTH];
	int                  count_mirror = 0;
	search_result_t      pending_results[$];

	int errors = 0;
	int requests_sent = 0;
	int loads_sent = 0;
	int searches_sent = 0;
	int hits_seen = 0;
	int misses_seen = 0;
	int count_writes = 0;
	int quiet_left = 0;
	int idle_cycles = 0;
	int stall_pick, stall_len;

	sorted_table_binary_search_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic search_result_t predict_search(
			input logic [stbs_pkg::KEY_IN_W-1:0] key);
		search_result_t r;
		int span, lo, hi, mid;
		span = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
		r.key = key;
		r.hit = 1'b0;
		r.pos = '0;
		lo = 0;
		hi = span - 1;
		while (lo <= hi && !r.hit) begin
			mid = (lo + hi) / 2;
			if (key_mirror[mid] == key) begin
				r.hit = 1'b1;
				r.pos = mid[stbs_pkg::POS_W-1:0];
			end else if (key_mirror[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return r;
	endfunction

	function automatic logic [stbs_pkg::KEY_IN_W-1:0] pick_search_key(input int span);
		int r;
		logic [stbs_pkg::KEY_IN_W-1:0] k;
		r = $urandom_range(0, 99);
		if (span > 0 && r < 50)
			return key_mirror[$urandom_range(0, span - 1)];
		if (span > 0 && r < 70) begin
			k = key_mirror[$urandom_range(0, span - 1)];
			return r[0] ? k + 1'b1 : k - 1'b1;
		end
		if (r < 74)
			return '0;
		if (r < 78)
			return '1;
		return $urandom;
	endfunction

	task automatic send_request(input logic req_mode, input logic [stbs_pkg::INDEX_W-1:0] idx,
			input logic [stbs_pkg::KEY_IN_W-1:0] key);
		int gap, r;
		in_valid <= 1'b1;
		mode <= req_mode;
		entry_index <= idx;
		key_value <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		if (req_mode == stbs_pkg::MODE_LOAD) begin
			key_mirror[idx] = key;
			loads_sent++;
		end else begin
			pending_results.push_back(predict_search(key));
			searches_sent++;
		end
		// mostly short gaps, now and then a long one or a run with none
		gap = 0;
		r = $urandom_range(0, 99);
		if (quiet_left > 0)
			quiet_left--;
		else if (r < 3)
			quiet_left = $urandom_range(20, 80);
		else if (r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic search_for(input logic [stbs_pkg::KEY_IN_W-1:0] key);
		send_request(stbs_pkg::MODE_SEARCH, index_t'($urandom_range(0, TABLE_DEPTH - 1)), key);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_entry_count(input logic [stbs_pkg::COUNT_W-1:0] value);
		wait_for_results();
		// loads give no result, so allow for one still in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_mirror = value;
		count_writes++;
	endtask

	task automatic test_empty_table();
		search_for('0);
		search_for('1);
	endtask

	task automatic test_small_table();
		send_request(stbs_pkg::MODE_LOAD, index_t'(0), 32'h0000_0000);
		send_request(stbs_pkg::MODE_LOAD, index_t'(1), 32'h5555_5555);
		send_request(stbs_pkg::MODE_LOAD, index_t'(2), 32'hAAAA_AAAA);
		send_request(stbs_pkg::MODE_LOAD, index_t'(3), 32'hFFFF_FFFF);
		write_entry_count(count_t'(1));
		search_for(32'h0000_0000);
		search_for(32'h0000_0001);
		write_entry_count(count_t'(4));
		search_for(32'hFFFF_FFFF);
		search_for(32'hAAAA_AAAA);
		search_for(32'h5555_5555);
		search_for(32'h8000_0000);
		search_for(32'h1234_5678);
	endtask

	task automatic test_duplicate_keys();
		send_request(stbs_pkg::MODE_LOAD, index_t'(0), 32'd5);
		send_request(stbs_pkg::MODE_LOAD, index_t'(1), 32'd7);
		send_request(stbs_pkg::MODE_LOAD, index_t'(2), 32'd7);
		send_request(stbs_pkg::MODE_LOAD, index_t'(3), 32'd7);
		search_for(32'd7);
		search_for(32'd5);
		search_for(32'd6);
	endtask

	task automatic test_unsorted_table();
		send_request(stbs_pkg::MODE_LOAD, index_t'(0), 32'd9);
		write_entry_count(count_t'(3));
		search_for(32'd9);
		search_for(32'd7);
	endtask

	task automatic test_full_table();
		logic [stbs_pkg::KEY_IN_W-1:0] fill_keys [TABLE_DEPTH];
		int fill_order [TABLE_DEPTH];
		int i, j, t;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			fill_order[i] = i;
			if (i > 0 && $urandom_range(0, 7) == 0)
				fill_keys[i] = fill_keys[i-1];
			else
				fill_keys[i] = i * 32'd4194304 + $urandom_range(0, 4194303);
		end
		fill_keys[0] = '0;
		fill_keys[TABLE_DEPTH-1] = '1;
		for (i = TABLE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = fill_order[i];
			fill_order[i] = fill_order[j];
			fill_order[j] = t;
		end
		for (i = 0; i < TABLE_DEPTH; i++)
			send_request(stbs_pkg::MODE_LOAD, index_t'(fill_order[i]),
				fill_keys[fill_order[i]]);
		write_entry_count(count_t'(TABLE_DEPTH));
		search_for('0);
		search_for('1);
		repeat (150) search_for(pick_search_key(TABLE_DEPTH));
	endtask

	task automatic test_count_clamp();
		write_entry_count('1);
		repeat (40) search_for(pick_search_key(TABLE_DEPTH));
		write_entry_count(count_t'(TABLE_DEPTH + 1));
		repeat (20) search_for(pick_search_key(TABLE_DEPTH));
	endtask

	task automatic test_random_phases();
		logic [63:0] lo_b, hi_b, v, step;
		int r, cnt, span, len, first, ops, i, drain_at;
		while (requests_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				cnt = 0;
			else if (r == 1)
				cnt = 1;
			else if (r == 2)
				cnt = 2;
			else if (r < 10)
				cnt = $urandom_range(3, 64);
			else if (r < 15)
				cnt = $urandom_range(65, TABLE_DEPTH - 1);
			else if (r < 18)
				cnt = TABLE_DEPTH;
			else if (r == 18)
				cnt = 2047;
			else
				cnt = $urandom_range(TABLE_DEPTH + 1, 2047);
			write_entry_count(count_t'(cnt));
			span = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

			// rewrite a window in order so the table stays mostly sorted
			if (span > 0 && $urandom_range(0, 2) != 0) begin
				len = $urandom_range(1, (span < 24) ? span : 24);
				first = $urandom_range(0, span - len);
				lo_b = (first > 0) ? 64'(key_mirror[first-1]) : 64'd0;
				hi_b = (first + len < TABLE_DEPTH) ? 64'(key_mirror[first+len])
					: 64'hFFFF_FFFF;
				if (lo_b > hi_b)
					hi_b = lo_b;
				step = (hi_b - lo_b) / (len + 1);
				v = lo_b;
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) != 0)
						v = v + ({$urandom, $urandom} % (2 * step + 1));
					if (v > hi_b)
						v = hi_b;
					send_request(stbs_pkg::MODE_LOAD, index_t'(first + i),
						v[stbs_pkg::KEY_IN_W-1:0]);
				end
			end

			ops = $urandom_range(8, 40);
			drain_at = ($urandom_range(0, 3) == 0) ? ops / 2 : -1;
			for (i = 0; i < ops; i++) begin
				if (i == drain_at)
					wait_for_results();
				if ($urandom_range(0, 99) < 4)
					send_request(stbs_pkg::MODE_LOAD,
						index_t'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
				else
					search_for(pick_search_key(span));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: found %0b position %0d", $time, found, position);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.hit) begin
					$display("%0t found mismatch for key %h: expected %0b, got %0b",
						$time, want.key, want.hit, found);
					errors++;
				end
				if (position !== want.pos) begin
					$display("%0t position mismatch for key %h: expected %0d, got %0d",
						$time, want.key, want.pos, position);
					errors++;
				end
				if (want.hit)
					hits_seen++;
				else
					misses_seen++;
			end
		end
	end

	// receiver back-pressure: quiet runs, random chatter, and the odd long hold
	initial begin
		forever begin
			stall_pick = $urandom_range(0, 9);
			if (stall_pick < 4) begin
				stall_len = $urandom_range(5, 40);
				repeat (stall_len) begin
					@(posedge clk);
					out_stall <= 1'b0;
				end
			end else if (stall_pick < 8) begin
				stall_len = $urandom_range(5, 40);
				repeat (stall_len) begin
					@(posedge clk);
					out_stall <= ($urandom_range(0, 9) < 3);
				end
			end else begin
				stall_len = (stall_pick == 8) ? $urandom_range(20, 60) : $urandom_range(1, 3);
				repeat (stall_len) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
				@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// no-progress watchdog; a result nobody asked for is not progress
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || cfg_we ||
					(out_valid && !out_stall && pending_results.size() != 0))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t no request or result moved for %0d cycles", $time, IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_small_table();
		test_duplicate_keys();
		test_unsorted_table();
		test_full_table();
		test_count_clamp();
		test_random_phases();

		wait_for_results();
		repeat (40) @(posedge clk);

		$display("covered %0d loads and %0d searches (%0d hits, %0d misses)",
			loads_sent, searches_sent, hits_seen, misses_seen);
		$display("across %0d entry_count settings, empty to beyond table depth", count_writes);
		if (errors == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
